// ----- design/assert_macros.svh -----
// Assertion macros used by the port-level checker of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define SRE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define SRE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- design/sre_pkg.sv -----
// Constants, codes and types shared by the static range encoder and its checker.
package sre_pkg;

  // Model and coder constants
  localparam int PROB_BITS     = 15;
  localparam int ALPHABET_SIZE = 4096;
  localparam int MAX_FF_RUN    = 32;
  localparam int MAX_RES       = 40;
  localparam int BYTE_POS      = 23;
  localparam logic [31:0] TOP_VAL    = 32'h8000_0000;
  localparam logic [31:0] BOTTOM_VAL = 32'h0080_0000;

  // Field and storage widths
  localparam int SYM_W   = 12;
  localparam int FREQ_W  = 16;
  localparam int CUM_W   = 15;
  localparam int ADDR_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int RUN_W   = $clog2(MAX_FF_RUN + 1);
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int R_W     = 32 - PROB_BITS;

  // Stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;

  // Input action codes carried on in_tuser
  typedef enum logic [IN_TUSER_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_t;

  // One table entry: frequency above cumulative frequency
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [CUM_W-1:0]  cum;
  } tbl_entry_t;

endpackage

// ----- design/static_range_encoder.sv -----
// Static range encoder: symbol table memory, coder update and byte sequencer.
// Load: writes the table, no beat; loads may follow back to back. Encode: accept, multiply, add
//   and range check, then the renormalization shifts, carry check, zeros and released bytes,
//   then closing the item. Flush: range check, carry, release of the held byte and its 0xFF run,
//   the four low bytes and closing the item; output stalls can hold the emitting steps.
// Reset is synchronous and active low; the symbol table is not cleared and must be loaded.
module static_range_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [11:0] symbol, [27:12] entry_probability, [42:28] entry_cumulative, rest zero
  input  logic [sre_pkg::IN_TDATA_W-1:0] in_tdata,
  // [1:0] action
  input  logic [sre_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] out_byte
  output logic [sre_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  // [0] block_end, [1] run_overflow
  output logic [sre_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import sre_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_MUL      = 10'b00_0000_0010,
    S_ADD      = 10'b00_0000_0100,
    S_CHK      = 10'b00_0000_1000,
    S_CARRY    = 10'b00_0001_0000,
    S_ZERO     = 10'b00_0010_0000,
    S_SHIFT    = 10'b00_0100_0000,
    S_REL_HELD = 10'b00_1000_0000,
    S_REL_RUN  = 10'b01_0000_0000,
    S_FIN      = 10'b10_0000_0000
  } state_t;

  // Input field split
  logic [SYM_W-1:0]  in_sym;
  logic [FREQ_W-1:0] in_freq;
  logic [CUM_W-1:0]  in_cum;
  logic              in_beat;
  logic              sym_ok;

  assign in_sym  = in_tdata[SYM_W-1:0];
  assign in_freq = in_tdata[SYM_W+FREQ_W-1:SYM_W];
  assign in_cum  = in_tdata[SYM_W+FREQ_W+CUM_W-1:SYM_W+FREQ_W];
  assign in_beat = in_tvalid && in_tready;
  assign sym_ok  = (32'(in_sym) < ALPHABET_SIZE);

  // Symbol table memory
  tbl_entry_t tbl_mem [ALPHABET_SIZE];
  tbl_entry_t rd_r;

  always_ff @(posedge clk) begin
    if (in_beat && (in_tuser == ACT_LOAD) && sym_ok) begin
      tbl_mem[in_sym[ADDR_W-1:0]] <= '{freq: in_freq, cum: in_cum};
    end
    if (in_beat) begin
      rd_r <= tbl_mem[in_sym[ADDR_W-1:0]];
    end
  end

  // Registers
  state_t           state_r, state_nxt;
  logic [31:0]      low_r, low_nxt;
  logic [31:0]      range_r, range_nxt;
  logic [31:0]      prod_r, prod_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             held_vld_r, held_vld_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic [RUN_W-1:0] zcnt_r, zcnt_nxt;
  logic             prev_bit_r, prev_bit_nxt;
  logic             ovf_r, ovf_nxt;
  logic             flush_r, flush_nxt;
  logic [2:0]       n_r, n_nxt;
  logic [1:0]       tidx_r, tidx_nxt;
  logic [7:0]       push_b_r, push_b_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       pend_byte_r, pend_byte_nxt;
  logic             pend_flag_r, pend_flag_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_end_r, out_end_nxt;
  logic             out_flag_r, out_flag_nxt;
  logic             out_vld_r, out_vld_nxt;

  // Coder arithmetic
  logic [R_W-1:0]        r_val;
  logic [R_W+FREQ_W-1:0] prod_f;
  logic [R_W+CUM_W-1:0]  prod_c;
  logic [31:0]           range_sh;
  logic [7:0]            shift_b;
  logic [7:0]            tail_b;

  assign r_val    = range_r[31:PROB_BITS];
  assign prod_f   = r_val * rd_r.freq;
  assign prod_c   = r_val * rd_r.cum;
  assign range_sh = {range_r[23:0], 8'h00};
  assign shift_b  = low_r[BYTE_POS+7:BYTE_POS];

  always_comb begin
    case (tidx_r)
      2'd0:    tail_b = low_r[30:23];
      2'd1:    tail_b = low_r[22:15];
      2'd2:    tail_b = low_r[14:7];
      default: tail_b = {low_r[6:0], 1'b0};
    endcase
  end

  // Sequencer, byte emitter and output stage
  always_comb begin
    logic       want_emit;
    logic [7:0] emit_b;
    logic       capped;
    logic       slot_free;
    logic       emit_ok;
    logic       go;
    logic       do_emit;
    logic       rel_done;
    logic       more_shift;

    state_nxt     = state_r;
    low_nxt       = low_r;
    range_nxt     = range_r;
    prod_nxt      = prod_r;
    held_nxt      = held_r;
    held_vld_nxt  = held_vld_r;
    run_nxt       = run_r;
    zcnt_nxt      = zcnt_r;
    prev_bit_nxt  = prev_bit_r;
    ovf_nxt       = ovf_r;
    flush_nxt     = flush_r;
    n_nxt         = n_r;
    tidx_nxt      = tidx_r;
    push_b_nxt    = push_b_r;
    cnt_nxt       = cnt_r;
    pend_byte_nxt = pend_byte_r;
    pend_flag_nxt = pend_flag_r;
    pend_vld_nxt  = pend_vld_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;
    out_flag_nxt  = out_flag_r;
    out_vld_nxt   = out_vld_r;
    rel_done      = 1'b0;
    more_shift    = (range_r <= BOTTOM_VAL) && !n_r[2];

    // Pick the byte this state wants to emit
    want_emit = 1'b0;
    emit_b    = 8'h00;
    case (state_r)
      S_CARRY: begin
        want_emit = held_vld_r && (run_r != '0);
        emit_b    = held_r + 8'd1;
      end
      S_ZERO: begin
        want_emit = 1'b1;
        emit_b    = 8'h00;
      end
      S_REL_HELD: begin
        want_emit = held_vld_r;
        emit_b    = held_r;
      end
      S_REL_RUN: begin
        want_emit = 1'b1;
        emit_b    = 8'hFF;
      end
      default: begin
        want_emit = 1'b0;
      end
    endcase
    // Flush tail: S_ADD emits the four low bytes
    if (state_r == S_ADD && flush_r) begin
      want_emit = 1'b1;
      emit_b    = tail_b;
    end

    capped    = (cnt_r == CNT_W'(MAX_RES));
    slot_free = !out_vld_r || out_tready;
    emit_ok   = !pend_vld_r || slot_free;
    go        = !want_emit || capped || emit_ok;
    do_emit   = want_emit && !capped && emit_ok;

    // Drain the output register
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    // Drop bytes beyond the per-item limit
    if (want_emit && capped) begin
      ovf_nxt = 1'b1;
    end

    // Shift the byte into the pending slot, pushing the older one out
    if (do_emit) begin
      if (pend_vld_r) begin
        out_byte_nxt = pend_byte_r;
        out_flag_nxt = pend_flag_r;
        out_last_nxt = 1'b0;
        out_end_nxt  = 1'b0;
        out_vld_nxt  = 1'b1;
      end
      pend_byte_nxt = {prev_bit_r, emit_b[7:1]};
      pend_flag_nxt = ovf_r;
      pend_vld_nxt  = 1'b1;
      prev_bit_nxt  = emit_b[0];
      cnt_nxt       = cnt_r + CNT_W'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          case (in_tuser)
            ACT_ENCODE: begin
              if (sym_ok) begin
                flush_nxt = 1'b0;
                cnt_nxt   = '0;
                state_nxt = S_MUL;
              end
            end
            ACT_FLUSH: begin
              flush_nxt = 1'b1;
              cnt_nxt   = '0;
              state_nxt = S_CHK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_MUL: begin
        prod_nxt  = 32'(prod_c);
        range_nxt = prod_f[31:0];
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (flush_r) begin
          // Emit the four low bytes, then start a new block
          if (go) begin
            tidx_nxt = tidx_r + 2'd1;
            if (tidx_r == 2'd3) begin
              low_nxt      = '0;
              range_nxt    = TOP_VAL;
              held_nxt     = '0;
              held_vld_nxt = 1'b0;
              run_nxt      = '0;
              prev_bit_nxt = 1'b0;
              state_nxt    = S_FIN;
            end
          end
        end else begin
          low_nxt   = low_r + prod_r;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        n_nxt    = '0;
        tidx_nxt = '0;
        if (flush_r) begin
          state_nxt = low_r[31] ? S_CARRY : S_REL_HELD;
        end else if (range_r <= BOTTOM_VAL) begin
          state_nxt = low_r[31] ? S_CARRY : S_SHIFT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CARRY: begin
        if (!held_vld_r) begin
          state_nxt = flush_r ? S_REL_HELD : S_SHIFT;
        end else if (run_r == '0) begin
          held_nxt  = held_r + 8'd1;
          state_nxt = flush_r ? S_REL_HELD : S_SHIFT;
        end else if (go) begin
          held_nxt  = '0;
          run_nxt   = '0;
          zcnt_nxt  = run_r - RUN_W'(1);
          if (run_r == RUN_W'(1)) begin
            state_nxt = flush_r ? S_REL_HELD : S_SHIFT;
          end else begin
            state_nxt = S_ZERO;
          end
        end
      end
      S_ZERO: begin
        if (go) begin
          zcnt_nxt = zcnt_r - RUN_W'(1);
          if (zcnt_r == RUN_W'(1)) begin
            state_nxt = flush_r ? S_REL_HELD : S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // One renormalization step: shift out the top byte of low
        range_nxt  = range_sh;
        low_nxt    = {1'b0, low_r[22:0], 8'h00};
        n_nxt      = n_r + 3'd1;
        push_b_nxt = shift_b;
        if (held_vld_r && (shift_b == 8'hFF) && (run_r < RUN_W'(MAX_FF_RUN))) begin
          run_nxt   = run_r + RUN_W'(1);
          state_nxt = ((range_sh <= BOTTOM_VAL) && (n_r < 3'd3)) ? S_SHIFT : S_FIN;
        end else if (held_vld_r) begin
          if (shift_b == 8'hFF) begin
            ovf_nxt = 1'b1;
          end
          state_nxt = S_REL_HELD;
        end else begin
          held_nxt     = shift_b;
          held_vld_nxt = 1'b1;
          state_nxt    = ((range_sh <= BOTTOM_VAL) && (n_r < 3'd3)) ? S_SHIFT : S_FIN;
        end
      end
      S_REL_HELD: begin
        if (go) begin
          if (run_r != '0) begin
            state_nxt = S_REL_RUN;
          end else begin
            rel_done = 1'b1;
          end
        end
      end
      S_REL_RUN: begin
        if (go) begin
          run_nxt = run_r - RUN_W'(1);
          if (run_r == RUN_W'(1)) begin
            rel_done = 1'b1;
          end
        end
      end
      S_FIN: begin
        // Close the item: the pending byte becomes its last beat
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_byte_nxt = pend_byte_r;
          out_flag_nxt = pend_flag_r;
          out_last_nxt = 1'b1;
          out_end_nxt  = flush_r;
          out_vld_nxt  = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Finish a release of the held byte and its run
    if (rel_done) begin
      held_vld_nxt = 1'b0;
      run_nxt      = '0;
      if (flush_r) begin
        tidx_nxt  = '0;
        state_nxt = S_ADD;
      end else begin
        held_nxt     = push_b_r;
        held_vld_nxt = 1'b1;
        state_nxt    = more_shift ? S_SHIFT : S_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      low_r      <= '0;
      range_r    <= TOP_VAL;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      run_r      <= '0;
      prev_bit_r <= 1'b0;
      ovf_r      <= 1'b0;
      flush_r    <= 1'b0;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      low_r      <= low_nxt;
      range_r    <= range_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      run_r      <= run_nxt;
      prev_bit_r <= prev_bit_nxt;
      ovf_r      <= ovf_nxt;
      flush_r    <= flush_nxt;
      cnt_r      <= cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r      <= prod_nxt;
    zcnt_r      <= zcnt_nxt;
    n_r         <= n_nxt;
    tidx_r      <= tidx_nxt;
    push_b_r    <= push_b_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_flag_r <= pend_flag_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_end_r   <= out_end_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_flag_r, out_end_r};

endmodule

// ----- design/sre_checker.sv -----
// Port-level checker for the static range encoder, bound to the top level.
`include "assert_macros.svh"

module sre_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  // [7:0] out_byte
  input logic [sre_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  // [0] block_end, [1] run_overflow
  input logic [sre_pkg::OUT_TUSER_W-1:0] out_tuser
);

  logic ovf_seen_r;
  logic out_stall;
  logic mid_item;

  assign out_stall = out_tvalid && !out_tready;
  assign mid_item  = out_tvalid && !out_tlast;

  // Remember a flagged overflow beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_seen_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tuser[1]) begin
      ovf_seen_r <= 1'b1;
    end
  end

  // A stalled result beat holds its byte
  `SRE_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_tvalid && $stable(out_tdata), "beat changed")

  // An item with beats still to come takes no new input
  `SRE_ASSERT_NEVER(a_busy_mid_item, clk, rst_n, mid_item && in_tready, "ready mid item")

  // Block end only marks the last beat of an item
  `SRE_ASSERT(a_end_is_last, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tlast, "end not last")

  // Overflow flag stays set once seen
  `SRE_ASSERT(a_ovf_sticky, clk, rst_n, out_tvalid && ovf_seen_r |-> out_tuser[1], "overflow dropped")

endmodule

bind static_range_encoder sre_checker u_sre_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for the static range encoder: stream driver, byte monitor, predictor.
`timescale 1ns / 100ps

module testbench;
  import sre_pkg::*;

  // Reserved action code: the block drops such beats
  localparam logic [IN_TUSER_W-1:0] ACT_RSVD = 2'd3;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = 60;
  localparam int QUIET_ITEMS  = 40;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 60;
  localparam int RANDOM_ITEMS = 220;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [IN_TUSER_W-1:0] act;
    logic [SYM_W-1:0]      sym;
    logic [FREQ_W-1:0]     freq;
    logic [CUM_W-1:0]      cum;
    bit                    drain;
  } coder_cmd_t;

  typedef struct {
    logic [7:0] code;
    bit         last;
    bit         blk_end;
    bit         ovf;
  } coded_byte_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // Stimulus and expected output bytes
  coder_cmd_t  cmd_q[$];
  coded_byte_t byte_q[$];
  int          cmd_count = 0;

  // Predictor state
  logic [31:0]       enc_low;
  logic [31:0]       enc_range;
  logic [7:0]        stash_byte;
  bit                stash_ok;
  int unsigned       ff_run;
  bit                shift_bit;
  bit                ovf_flag = 1'b0;
  logic [FREQ_W-1:0] freq_mem[ALPHABET_SIZE];
  logic [CUM_W-1:0]  cum_mem[ALPHABET_SIZE];
  coded_byte_t       step_q[$];

  // Handshake bookkeeping
  int          cycle_cnt  = 0;
  int          taken_cnt  = 0;
  bit          in_fire    = 1'b0;
  int          gap_left   = 0;
  int          hold_left  = 0;
  bit          long_done  = 1'b0;
  int          mismatches = 0;
  int          checked    = 0;
  coder_cmd_t  next_cmd;
  coded_byte_t want;

  static_range_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue one command for the driver
  task automatic add_cmd(input logic [IN_TUSER_W-1:0] act, input logic [SYM_W-1:0] sym,
                         input logic [FREQ_W-1:0] freq, input logic [CUM_W-1:0] cum,
                         input bit drain);
    coder_cmd_t c;
    c.act   = act;
    c.sym   = sym;
    c.freq  = freq;
    c.cum   = cum;
    c.drain = drain;
    cmd_q.push_back(c);
    if (act != ACT_RSVD) cmd_count++;
  endtask

  // Emit one raw byte through the one-bit stream shift
  task automatic emit_shifted(input logic [7:0] raw);
    coded_byte_t cb;
    if (step_q.size() >= MAX_RES) begin
      ovf_flag = 1'b1;
    end else begin
      cb.code    = {shift_bit, raw[7:1]};
      cb.last    = 1'b0;
      cb.blk_end = 1'b0;
      cb.ovf     = ovf_flag;
      step_q.push_back(cb);
      shift_bit = raw[0];
    end
  endtask

  // Release the held byte and its 0xFF run
  task automatic release_stash();
    if (stash_ok) emit_shifted(stash_byte);
    repeat (ff_run) emit_shifted(8'hFF);
    ff_run   = 0;
    stash_ok = 1'b0;
  endtask

  // Add a carry into the held byte, resolving a pending 0xFF run
  task automatic propagate_carry();
    if (stash_ok) begin
      if (ff_run == 0) begin
        stash_byte = stash_byte + 8'd1;
      end else begin
        emit_shifted(stash_byte + 8'd1);
        repeat (ff_run - 1) emit_shifted(8'h00);
        stash_byte = '0;
        ff_run     = 0;
      end
    end
  endtask

  // Hold back a new coder byte, extending the 0xFF run where possible
  task automatic push_coded(input logic [7:0] b);
    if (stash_ok && b == 8'hFF && ff_run < MAX_FF_RUN) begin
      ff_run++;
    end else begin
      if (stash_ok && b == 8'hFF) ovf_flag = 1'b1;
      if (stash_ok) release_stash();
      stash_byte = b;
      stash_ok   = 1'b1;
    end
  endtask

  task automatic restart_block();
    enc_low    = '0;
    enc_range  = TOP_VAL;
    stash_byte = '0;
    stash_ok   = 1'b0;
    ff_run     = 0;
    shift_bit  = 1'b0;
  endtask

  // Work out the output bytes of one accepted command
  task automatic predict_coder(input logic [IN_TUSER_W-1:0] act, input logic [SYM_W-1:0] sym,
                               input logic [FREQ_W-1:0] freq, input logic [CUM_W-1:0] cum);
    logic [31:0] r;
    logic [31:0] lo;
    int          n;
    coded_byte_t cb;
    step_q.delete();
    case (act)
      ACT_LOAD: begin
        freq_mem[sym] = freq;
        cum_mem[sym]  = cum;
      end
      ACT_ENCODE: begin
        r         = enc_range >> PROB_BITS;
        enc_low   = enc_low + r * cum_mem[sym];
        enc_range = r * freq_mem[sym];
        if (enc_range <= BOTTOM_VAL) begin
          if ((enc_low & TOP_VAL) != 0) propagate_carry();
          n = 0;
          do begin
            enc_range = enc_range << 8;
            push_coded(8'(enc_low >> BYTE_POS));
            enc_low = (enc_low << 8) & (TOP_VAL - 1);
            n++;
          end while (enc_range <= BOTTOM_VAL && n < 4);
        end
      end
      ACT_FLUSH: begin
        if ((enc_low & TOP_VAL) != 0) propagate_carry();
        release_stash();
        lo = enc_low;
        emit_shifted(8'(lo >> BYTE_POS));
        emit_shifted(8'(lo >> (BYTE_POS - 8)));
        emit_shifted(8'(lo >> (BYTE_POS - 16)));
        emit_shifted(8'(lo << 1));
        restart_block();
      end
      default: ;
    endcase
    for (n = 0; n < step_q.size(); n++) begin
      cb         = step_q[n];
      cb.last    = (n == step_q.size() - 1);
      cb.blk_end = cb.last && (act == ACT_FLUSH);
      byte_q.push_back(cb);
    end
  endtask

  // Count cycles, take input beats and predict their bytes
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    in_fire   <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      predict_coder(in_tuser, in_tdata[SYM_W-1:0], in_tdata[SYM_W+FREQ_W-1:SYM_W],
                    in_tdata[SYM_W+FREQ_W+CUM_W-1:SYM_W+FREQ_W]);
      taken_cnt <= taken_cnt + 1;
    end
  end

  // Drive input beats at the falling edge; hold a beat until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      in_tvalid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      in_tvalid <= 1'b0;
    end else if (cmd_q.size() != 0 && (!cmd_q[0].drain || byte_q.size() == 0)) begin
      if (cmd_q.size() >= QUIET_ITEMS && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(0, 4);
        in_tvalid <= 1'b0;
      end else begin
        next_cmd = cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= next_cmd.act;
        in_tdata  <= {{(IN_TDATA_W-SYM_W-FREQ_W-CUM_W){1'b0}},
                      next_cmd.cum, next_cmd.freq, next_cmd.sym};
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Stall the output side in short bursts, and once for a long stretch
  always @(negedge clk) begin
    if (!long_done && taken_cnt >= HOLD_AFTER) begin
      long_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (cmd_q.size() >= QUIET_ITEMS && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each output beat with the oldest expected byte
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      checked++;
      if (byte_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("byte %0d: unexpected beat data %h last %b user %b",
                   checked, out_tdata, out_tlast, out_tuser);
      end else begin
        want = byte_q.pop_front();
        if (out_tdata !== want.code || out_tlast !== want.last ||
            out_tuser[0] !== want.blk_end || out_tuser[1] !== want.ovf) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("byte %0d: expected %h last %b end %b ovf %b, got %h last %b end %b ovf %b",
                     checked, want.code, want.last, want.blk_end, want.ovf,
                     out_tdata, out_tlast, out_tuser[0], out_tuser[1]);
        end
      end
    end
  end

  initial begin
    logic [SYM_W-1:0]  syms[$];
    logic [SYM_W-1:0]  s;
    logic [FREQ_W-1:0] f;
    int unsigned       acc;
    int                n_sym;
    int                k;
    bit                dup;
    bit                first;

    restart_block();

    // Empty block, table extremes, an all-ones symbol driven into a long 0xFF run
    add_cmd(ACT_FLUSH, '0, '0, '0, 1'b0);
    add_cmd(ACT_LOAD, {SYM_W{1'b1}}, 16'd1, {CUM_W{1'b1}}, 1'b0);
    add_cmd(ACT_LOAD, '0, 16'd32768, '0, 1'b0);
    add_cmd(ACT_ENCODE, '0, '0, '0, 1'b0);
    add_cmd(ACT_RSVD, {SYM_W{1'b1}}, 16'd32768, {CUM_W{1'b1}}, 1'b0);
    repeat (19) add_cmd(ACT_ENCODE, {SYM_W{1'b1}}, '0, '0, 1'b0);
    add_cmd(ACT_FLUSH, '0, '0, '0, 1'b0);

    // Random blocks: mostly consistent tables, some stray entries and reserved beats
    first = 1'b1;
    while (cmd_count < RANDOM_ITEMS - 20) begin
      syms.delete();
      if ($urandom_range(0, 9) < 8) begin
        n_sym = $urandom_range(2, 8);
        while (syms.size() < n_sym) begin
          s = ($urandom_range(0, 3) == 0) ? SYM_W'($urandom_range(0, ALPHABET_SIZE - 1))
                                          : SYM_W'($urandom_range(0, 15));
          dup = 1'b0;
          foreach (syms[j]) if (syms[j] == s) dup = 1'b1;
          if (!dup) syms.push_back(s);
        end
        // Split the full probability scale over the chosen symbols
        acc = 0;
        for (k = 0; k < n_sym; k++) begin
          f = (k == n_sym - 1) ? FREQ_W'(32768 - acc)
                               : FREQ_W'($urandom_range(1, 32768 - acc - (n_sym - 1 - k)));
          add_cmd(ACT_LOAD, syms[k], f, CUM_W'(acc), first || $urandom_range(0, 7) == 0);
          first = 1'b0;
          acc += f;
        end
        repeat ($urandom_range(3, 24)) begin
          if ($urandom_range(0, 19) == 0)
            add_cmd(ACT_RSVD, SYM_W'($urandom), FREQ_W'($urandom), CUM_W'($urandom), 1'b0);
          add_cmd(ACT_ENCODE, syms[$urandom_range(0, n_sym - 1)], '0, '0, 1'b0);
        end
        add_cmd(ACT_FLUSH, SYM_W'($urandom), FREQ_W'($urandom), CUM_W'($urandom), 1'b0);
      end else begin
        // Stray entries with unrelated fields, possibly left unflushed
        repeat ($urandom_range(1, 4)) begin
          s = SYM_W'($urandom_range(0, ALPHABET_SIZE - 1));
          syms.push_back(s);
          add_cmd(ACT_LOAD, s, FREQ_W'($urandom_range(1, 32768)),
                  CUM_W'($urandom_range(0, 32767)), 1'b0);
        end
        repeat ($urandom_range(1, 10))
          add_cmd(ACT_ENCODE, syms[$urandom_range(0, syms.size() - 1)], '0, '0, 1'b0);
        if ($urandom_range(0, 1) == 0) add_cmd(ACT_FLUSH, '0, '0, '0, 1'b0);
      end
    end
    add_cmd(ACT_FLUSH, '0, '0, '0, 1'b0);

    // Hold reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while ((cmd_q.size() != 0 || in_tvalid || byte_q.size() != 0) && cycle_cnt < CYCLE_LIMIT)
      @(posedge clk);
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("static_range_encoder: mismatch");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (mismatches == 0)
        $display("static_range_encoder: match");
      else
        $display("static_range_encoder: mismatch");
    end
    $finish;
  end

endmodule

// ----- static_range_encoder.f -----
+incdir+design
design/sre_pkg.sv
design/static_range_encoder.sv
design/sre_checker.sv
sim/testbench.sv
